FILE: src/fpff_pkg.sv
package fpff_pkg;

  // table geometry
  localparam int TableDepth = 16;
  localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int PtrW       = $clog2(TableDepth + 1);

  // fixed field widths of the channels
  localparam int OpW      = 2;
  localparam int FieldIdxW = 4;
  localparam int WordW    = 16;
  localparam int CountW   = 5;
  localparam int StatusW  = 2;

  typedef enum logic [OpW-1:0] {
    OP_LOAD    = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STAT_DONE   = 2'd0,
    STAT_NOFIT  = 2'd1,
    STAT_BADJOB = 2'd2
  } status_e;

  // one partition entry
  typedef struct packed {
    logic [WordW-1:0] start;
    logic [WordW-1:0] length;
    logic [WordW-1:0] owner;
  } entry_t;

  // write port of the partition table
  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    entry_t          data;
  } tbl_wr_t;

  // read request of the partition table
  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
  } tbl_rd_t;

endpackage

FILE: src/fpff_table.sv
module fpff_table (
  input  logic             clk_i,
  input  fpff_pkg::tbl_wr_t wr_i,
  input  fpff_pkg::tbl_rd_t rd_i,
  output fpff_pkg::entry_t  rd_data_o
);
  import fpff_pkg::*;

  entry_t mem_q [TableDepth];
  entry_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: src/fixed_partition_first_fit.sv
// fixed-partition first-fit allocator
//
// input channel (in_valid_i / in_ready_o): one beat is one item. op 0 loads a
// table entry, op 1 allocates the lowest free entry longer than request_size,
// op 2 releases every scanned entry owned by job_id. op 3 does nothing.
// output channel (out_valid_o / out_ready_i): exactly one result beat per item.
// config channel (cfg_valid_i / cfg_ready_o): writes partition_count, always
// ready; write it only while no item is in flight.
//
// timing: one item at a time. a load or a bad job id skips the scan state,
// which a scan over zero entries still passes. allocate and release scan the
// table one entry per cycle through its single read port, pipelined with the
// owner write-back, over partition_count entries (saturated at 16), fewer
// when allocate hits early. the next beat is taken in the cycle after the
// result is staged into the output register, even while it still waits.
//
// reset clears control state and partition_count. table contents are
// undefined until loaded; no clearing pass is made. a stalled receiver holds
// the result in the output register and the block waits before staging the
// next one.
module fixed_partition_first_fit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fpff_pkg::CountW-1:0]     cfg_data_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [fpff_pkg::OpW-1:0]        op_i,
  input  logic [fpff_pkg::FieldIdxW-1:0]  entry_index_i,
  input  logic [fpff_pkg::WordW-1:0]      entry_start_i,
  input  logic [fpff_pkg::WordW-1:0]      entry_length_i,
  input  logic [fpff_pkg::WordW-1:0]      job_id_i,
  input  logic [fpff_pkg::WordW-1:0]      request_size_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [fpff_pkg::StatusW-1:0]    status_o,
  output logic [fpff_pkg::FieldIdxW-1:0]  found_index_o,
  output logic [fpff_pkg::WordW-1:0]      found_start_o,
  output logic [fpff_pkg::WordW-1:0]      found_length_o,
  output logic [fpff_pkg::CountW-1:0]     freed_count_o
);
  import fpff_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CountW-1:0] cfg_count_q;
  logic [PtrW-1:0]   limit;

  // item registers
  op_e              op_q;
  logic [WordW-1:0] job_q;
  logic [WordW-1:0] req_q;

  // scan registers
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic            rvalid_q, rvalid_d;
  logic [IdxW-1:0] ridx_q, ridx_d;
  logic            hit_q, hit_d;

  // staged result
  status_e          res_status_q, res_status_d;
  logic [IdxW-1:0]  res_index_q, res_index_d;
  logic [WordW-1:0] res_start_q, res_start_d;
  logic [WordW-1:0] res_length_q, res_length_d;
  logic [PtrW-1:0]  freed_q, freed_d;

  // output register
  logic                 out_valid_q;
  logic                 out_load;
  logic [StatusW-1:0]   out_status_q;
  logic [FieldIdxW-1:0] out_index_q;
  logic [WordW-1:0]     out_start_q;
  logic [WordW-1:0]     out_length_q;
  logic [CountW-1:0]    out_freed_q;

  // table ports
  tbl_wr_t tbl_wr;
  tbl_rd_t tbl_rd;
  entry_t  rd_data;

  logic in_fire;
  logic alloc_hit;
  logic rel_hit;
  logic issue;

  fpff_table u_table (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_i      (tbl_rd),
    .rd_data_o (rd_data)
  );

  // config register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_count_q <= cfg_data_i;
    end
  end

  // scan limit saturates at the table depth
  assign limit = (int'(cfg_count_q) > TableDepth) ? PtrW'(TableDepth) : PtrW'(cfg_count_q);

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // latch the item
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= op_e'(op_i);
      job_q <= job_id_i;
      req_q <= request_size_i;
    end
  end

  // evaluation of the entry read in the previous cycle
  assign alloc_hit = rvalid_q && (op_q == OP_ALLOC) && (rd_data.owner == '0)
                     && (rd_data.length > req_q);
  assign rel_hit   = rvalid_q && (op_q == OP_RELEASE) && (rd_data.owner == job_q);
  assign issue     = (state_q == S_SCAN) && (ptr_q < limit) && !hit_q && !alloc_hit;

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // control and table access
  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    rvalid_d     = 1'b0;
    ridx_d       = ridx_q;
    hit_d        = hit_q;
    freed_d      = freed_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    res_start_d  = res_start_q;
    res_length_d = res_length_q;
    tbl_wr       = '0;
    tbl_rd.en    = 1'b0;
    tbl_rd.addr  = ptr_q[IdxW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_status_d = STAT_DONE;
          res_index_d  = '0;
          res_start_d  = '0;
          res_length_d = '0;
          freed_d      = '0;
          hit_d        = 1'b0;
          ptr_d        = '0;
          state_d      = S_DONE;
          unique case (op_e'(op_i)) inside
            OP_LOAD: begin
              if (int'(entry_index_i) < TableDepth) begin
                tbl_wr.en          = 1'b1;
                tbl_wr.addr        = IdxW'(entry_index_i);
                tbl_wr.data.start  = entry_start_i;
                tbl_wr.data.length = entry_length_i;
                tbl_wr.data.owner  = job_id_i;
              end
            end
            OP_ALLOC, OP_RELEASE: begin
              if (job_id_i == '0) begin
                res_status_d = STAT_BADJOB;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        // owner write-back of the evaluated entry
        if (alloc_hit || rel_hit) begin
          tbl_wr.en          = 1'b1;
          tbl_wr.addr        = ridx_q;
          tbl_wr.data.start  = rd_data.start;
          tbl_wr.data.length = rd_data.length;
          tbl_wr.data.owner  = alloc_hit ? job_q : '0;
        end
        if (alloc_hit) begin
          hit_d        = 1'b1;
          res_index_d  = ridx_q;
          res_start_d  = rd_data.start;
          res_length_d = rd_data.length;
        end
        if (rel_hit) begin
          freed_d = freed_q + PtrW'(1);
        end
        // next read
        if (issue) begin
          tbl_rd.en = 1'b1;
          ptr_d     = ptr_q + PtrW'(1);
          rvalid_d  = 1'b1;
          ridx_d    = ptr_q[IdxW-1:0];
        end
        // scan finished
        if (!issue && !rvalid_q) begin
          res_status_d = ((op_q == OP_ALLOC) && !hit_q) ? STAT_NOFIT : STAT_DONE;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rvalid_q <= 1'b0;
      hit_q    <= 1'b0;
      ptr_q    <= '0;
      freed_q  <= '0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= rvalid_d;
      hit_q    <= hit_d;
      ptr_q    <= ptr_d;
      freed_q  <= freed_d;
    end
  end

  // staged result payload
  always_ff @(posedge clk_i) begin
    ridx_q       <= ridx_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    res_start_q  <= res_start_d;
    res_length_q <= res_length_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_index_q  <= FieldIdxW'(res_index_q);
      out_start_q  <= res_start_q;
      out_length_q <= res_length_q;
      out_freed_q  <= CountW'(freed_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign found_index_o  = out_index_q;
  assign found_start_o  = out_start_q;
  assign found_length_o = out_length_q;
  assign freed_count_o  = out_freed_q;

  // read data is only pending during a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> (state_q == S_SCAN))
    else $error("read data pending outside scan");

  // write-back never targets the entry being read in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tbl_wr.en && tbl_rd.en) |-> (tbl_wr.addr != tbl_rd.addr))
    else $error("table read and write collide");

  // an allocate grants at most once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> !alloc_hit)
    else $error("second grant within one allocate");

  // freed count never exceeds the scanned range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (freed_q <= ptr_q))
    else $error("freed count ahead of scan pointer");

  // a result is staged into the output only when the register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

endmodule

FILE: tb/tb_fixed_partition_first_fit.sv
module tb_fixed_partition_first_fit;
  timeunit 1ns;
  timeprecision 1ps;

  import fpff_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int SettleCycles  = 20;
  localparam int RxHoldCycles  = 150;
  localparam int NumPhases     = 3;
  localparam int SegsPerPhase  = 6;
  localparam int ItemsPerSeg   = 72;
  localparam int JobPool       = 6;
  localparam int ReportLimit   = 10;

  // op 3 has no meaning in the block and must change nothing
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]       op;
    logic [FieldIdxW-1:0] index;
    logic [WordW-1:0]     start;
    logic [WordW-1:0]     length;
    logic [WordW-1:0]     job;
    logic [WordW-1:0]     size;
  } request_t;

  typedef struct packed {
    logic [StatusW-1:0]   status;
    logic [FieldIdxW-1:0] index;
    logic [WordW-1:0]     start;
    logic [WordW-1:0]     length;
    logic [CountW-1:0]    freed;
  } reply_t;

  typedef struct packed {
    bit                is_cfg;
    logic [CountW-1:0] cfg_val;
    request_t          rq;
    bit                typed;
    reply_t            rp;
  } step_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CountW-1:0]    cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [OpW-1:0]       op_i;
  logic [FieldIdxW-1:0] entry_index_i;
  logic [WordW-1:0]     entry_start_i;
  logic [WordW-1:0]     entry_length_i;
  logic [WordW-1:0]     job_id_i;
  logic [WordW-1:0]     request_size_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [StatusW-1:0]   status_o;
  logic [FieldIdxW-1:0] found_index_o;
  logic [WordW-1:0]     found_start_o;
  logic [WordW-1:0]     found_length_o;
  logic [CountW-1:0]    freed_count_o;

  fixed_partition_first_fit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .entry_index_i  (entry_index_i),
    .entry_start_i  (entry_start_i),
    .entry_length_i (entry_length_i),
    .job_id_i       (job_id_i),
    .request_size_i (request_size_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .found_index_o  (found_index_o),
    .found_start_o  (found_start_o),
    .found_length_o (found_length_o),
    .freed_count_o  (freed_count_o)
  );

  // mirror of the partition table and the scan count
  entry_t            part_tbl [TableDepth];
  logic [CountW-1:0] part_count;

  reply_t awaited_replies [$];
  step_t  stim_table [$];

  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int rx_hold_left  = 0;
  int mismatches    = 0;
  int idle_cycles   = 0;
  int request_count = 0;
  int cfg_writes    = 0;
  int grant_count   = 0;
  int nofit_count   = 0;
  int freed_total   = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // load, first-fit allocate and release on the mirror, returns the reply beat
  function automatic reply_t serve_request(input request_t rq);
    reply_t rp;
    int     limit;
    bit     hit;
    rp     = '0;
    rp.status = STAT_DONE;
    hit    = 1'b0;
    limit  = (int'(part_count) > TableDepth) ? TableDepth : int'(part_count);
    case (rq.op)
      OP_LOAD: begin
        if (int'(rq.index) < TableDepth) begin
          part_tbl[rq.index].start  = rq.start;
          part_tbl[rq.index].length = rq.length;
          part_tbl[rq.index].owner  = rq.job;
        end
      end
      OP_ALLOC: begin
        if (rq.job == '0) begin
          rp.status = STAT_BADJOB;
        end else begin
          for (int i = 0; i < limit && !hit; i++) begin
            if (part_tbl[i].owner == '0 && part_tbl[i].length > rq.size) begin
              part_tbl[i].owner = rq.job;
              rp.index  = i[FieldIdxW-1:0];
              rp.start  = part_tbl[i].start;
              rp.length = part_tbl[i].length;
              hit = 1'b1;
            end
          end
          if (hit) begin
            grant_count++;
          end else begin
            rp.status = STAT_NOFIT;
            nofit_count++;
          end
        end
      end
      OP_RELEASE: begin
        if (rq.job == '0) begin
          rp.status = STAT_BADJOB;
        end else begin
          for (int i = 0; i < limit; i++) begin
            if (part_tbl[i].owner == rq.job) begin
              part_tbl[i].owner = '0;
              rp.freed = rp.freed + CountW'(1);
            end
          end
          freed_total += int'(rp.freed);
        end
      end
      default: ;
    endcase
    return rp;
  endfunction

  // directed table rows
  function automatic void table_cfg(input logic [CountW-1:0] v);
    step_t s;
    s = '0;
    s.is_cfg  = 1'b1;
    s.cfg_val = v;
    stim_table.push_back(s);
  endfunction

  function automatic void table_req(input logic [OpW-1:0] op, input logic [FieldIdxW-1:0] idx,
                                    input logic [WordW-1:0] st, input logic [WordW-1:0] len,
                                    input logic [WordW-1:0] job, input logic [WordW-1:0] size,
                                    input bit typed, input logic [StatusW-1:0] status);
    step_t s;
    s = '0;
    s.rq.op     = op;
    s.rq.index  = idx;
    s.rq.start  = st;
    s.rq.length = len;
    s.rq.job    = job;
    s.rq.size   = size;
    s.typed     = typed;
    s.rp.status = status;
    stim_table.push_back(s);
  endfunction

  // job id: mostly from a small pool so releases find owners
  function automatic logic [WordW-1:0] pick_job();
    int p;
    p = $urandom_range(99);
    if (p < 85) return WordW'($urandom_range(1, JobPool));
    if (p < 90) return '0;
    return WordW'($urandom);
  endfunction

  // random request beat with all unused fields randomized too
  function automatic request_t random_request();
    request_t    rq;
    logic [95:0] raw;
    int          p;
    int          e;
    raw = {$urandom, $urandom, $urandom};
    rq  = raw[$bits(request_t)-1:0];
    p   = $urandom_range(99);
    e   = $urandom_range(0, TableDepth - 1);
    if (p < 30) begin
      rq.op = OP_LOAD;
      if ($urandom_range(1)) rq.length = WordW'($urandom_range(0, 1023));
      p = $urandom_range(99);
      if (p < 60) rq.job = '0;
      else if (p < 85) rq.job = WordW'($urandom_range(1, JobPool));
    end else if (p < 70) begin
      rq.op  = OP_ALLOC;
      rq.job = pick_job();
      p = $urandom_range(99);
      // boundary: request equal to or one below a table length
      if (p < 40) rq.size = part_tbl[e].length - WordW'($urandom_range(0, 1));
      else if (p < 60) rq.size = WordW'($urandom_range(0, 255));
    end else if (p < 95) begin
      rq.op  = OP_RELEASE;
      rq.job = pick_job();
    end else begin
      rq.op = OP_UNUSED;
    end
    return rq;
  endfunction

  // one input beat, predicted at the edge where it is taken
  task automatic offer_request(input request_t rq, input bit typed, input reply_t typed_rp);
    reply_t rp;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= rq.op;
    entry_index_i  <= rq.index;
    entry_start_i  <= rq.start;
    entry_length_i <= rq.length;
    job_id_i       <= rq.job;
    request_size_i <= rq.size;
    do @(posedge clk_i); while (!in_ready_o);
    rp = serve_request(rq);
    awaited_replies.push_back(typed ? typed_rp : rp);
    request_count++;
  endtask

  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
  endtask

  // register write only once the block has gone quiet
  task automatic write_partition_count(input logic [CountW-1:0] v);
    drain_replies();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    part_count = v;
    cfg_writes++;
  endtask

  // receiver side: random stalls plus an occasional long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // compare each reply beat against the oldest prediction
  always @(posedge clk_i) begin : check_replies
    reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected reply: status %0d idx %0d start %h len %h freed %0d",
                   status_o, found_index_o, found_start_o, found_length_o, freed_count_o);
      end else begin
        want = awaited_replies.pop_front();
        if (want.status !== status_o || want.index !== found_index_o ||
            want.start !== found_start_o || want.length !== found_length_o ||
            want.freed !== freed_count_o) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("reply mismatch: exp status %0d idx %0d start %h len %h freed %0d",
                     want.status, want.index, want.start, want.length, want.freed);
            $display("                got status %0d idx %0d start %h len %h freed %0d",
                     status_o, found_index_o, found_start_o, found_length_o, freed_count_o);
          end
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no beat for %0d cycles, %0d replies outstanding",
               idle_cycles, awaited_replies.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [CountW-1:0] seg_count;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    op_i           = OP_LOAD;
    entry_index_i  = '0;
    entry_start_i  = '0;
    entry_length_i = '0;
    job_id_i       = '0;
    request_size_i = '0;
    out_ready_i    = 1'b0;
    part_count     = '0;
    for (int e = 0; e < TableDepth; e++) part_tbl[e] = '0;

    // after reset the scan count is zero: nothing fits, nothing freed
    table_req(OP_ALLOC,   '0, '0, '0, 16'd5, '0, 1'b1, STAT_NOFIT);
    table_req(OP_RELEASE, '0, '0, '0, 16'd5, '0, 1'b1, STAT_DONE);
    // zero job id
    table_req(OP_ALLOC,   '0, '0, '0, '0, 16'h0040, 1'b1, STAT_BADJOB);
    table_req(OP_RELEASE, '0, '0, '0, '0, '0, 1'b1, STAT_BADJOB);
    // unused op with every field at its top
    table_req(OP_UNUSED, '1, '1, '1, '1, '1, 1'b1, STAT_DONE);
    // fill the whole table: length 0 and ffff, owners 0, 1 and ffff
    for (int e = 0; e < TableDepth; e++)
      table_req(OP_LOAD, e[FieldIdxW-1:0], WordW'(e * 16'h1111),
                (e == 1) ? 16'hFFFF : WordW'(e * 16'h0111),
                (e == 3) ? 16'hFFFF : ((e == 7) ? 16'h0001 : 16'h0000),
                WordW'($urandom), 1'b1, STAT_DONE);
    table_cfg(5'(TableDepth));
    // nothing is strictly longer than ffff
    table_req(OP_ALLOC, '0, '0, '0, 16'h00AB, 16'hFFFF, 1'b1, STAT_NOFIT);
    table_req(OP_ALLOC, '0, '0, '0, 16'h00AB, 16'h0000, 1'b0, STAT_DONE);
    // request equal to an entry length must skip that entry
    table_req(OP_ALLOC, '0, '0, '0, 16'h00AB, 16'h0222, 1'b0, STAT_DONE);
    // count above the table depth saturates
    table_cfg('1);
    table_req(OP_RELEASE, '0, '0, '0, 16'h00AB, '0, 1'b0, STAT_DONE);
    table_req(OP_RELEASE, '0, '0, '0, 16'hFFFF, '0, 1'b0, STAT_DONE);
    table_cfg(5'd1);
    table_req(OP_ALLOC, '0, '0, '0, 16'h0002, '0, 1'b0, STAT_DONE);

    tx_idle_pct = 34;
    rx_idle_pct = 79;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (stim_table[k]) begin
      if (stim_table[k].is_cfg) write_partition_count(stim_table[k].cfg_val);
      else offer_request(stim_table[k].rq, stim_table[k].typed, stim_table[k].rp);
    end

    // random phases, each a series of scan-count settings
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 34; rx_idle_pct = 79; end
        1: begin tx_idle_pct = 79; rx_idle_pct = 34; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int seg = 0; seg < SegsPerPhase; seg++) begin
        case (seg)
          0: seg_count = 5'(TableDepth);
          1: seg_count = 5'($urandom_range(1, TableDepth));
          2: seg_count = '1;
          3: seg_count = (ph == 0) ? '0 : 5'($urandom_range(0, 31));
          4: seg_count = 5'($urandom_range(2, TableDepth - 1));
          default: seg_count = 5'($urandom_range(0, 31));
        endcase
        write_partition_count(seg_count);
        for (int k = 0; k < ItemsPerSeg; k++) begin
          // sender pause until every reply is back
          if (ph == 0 && seg == 2 && k == ItemsPerSeg / 2) drain_replies();
          // long receiver hold-off while the sender keeps offering
          if (ph == 2 && seg == 1 && k == 10) rx_hold_left = RxHoldCycles;
          offer_request(random_request(), 1'b0, '0);
        end
      end
    end

    drain_replies();
    repeat (SettleCycles) @(posedge clk_i);
    $display("covered %0d requests over %0d scan-count writes, three stall mixes",
             request_count, cfg_writes);
    $display("first-fit grants %0d, no-fit %0d, entries freed %0d, mismatches %0d",
             grant_count, nofit_count, freed_total, mismatches);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
